[hdl/mpl_pkg.sv]
// Shared types and constants of the mesh point location block.
package mpl_pkg;

    localparam int COORD_W   = 24;
    localparam int MAX_NODES = 4096;
    localparam int MAX_TRIS  = 8192;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int TRI_AW    = $clog2(MAX_TRIS);
    localparam int SLOT_W    = 13;
    localparam int NC_W      = 13;
    localparam int TC_W      = 14;
    localparam int CFG_W     = 14;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int IN_DATA_W = 104;
    localparam int OUT_DATA_W = 32;

    localparam logic [1:0] ACT_NODE  = 2'd0;
    localparam logic [1:0] ACT_TRI   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_TRI_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        K_NODE,
        K_TRI,
        K_QUERY,
        K_SKIP
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [NODE_AW-1:0]         vertex_a;
        logic [NODE_AW-1:0]         vertex_b;
        logic [NODE_AW-1:0]         vertex_c;
    } t_item;

endpackage

[hdl/mpl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/mpl_front.sv]
// Input side: accepts items, classifies them and queues them for the sequencer.
module mpl_front
    import mpl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    input  logic [1:0]           i_s_user,
    input  logic [IN_DATA_W-1:0] i_s_data,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output t_item                o_q_item
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      n_item;
    logic       push;
    logic       pop;

    always_comb begin
        n_item.slot     = i_s_data[12:0];
        n_item.pos_x    = i_s_data[36:13];
        n_item.pos_y    = i_s_data[60:37];
        n_item.vertex_a = i_s_data[72:61];
        n_item.vertex_b = i_s_data[84:73];
        n_item.vertex_c = i_s_data[96:85];
        unique case (i_s_user)
            ACT_NODE:  n_item.kind = (i_s_data[12:0] < SLOT_W'(MAX_NODES)) ? K_NODE : K_SKIP;
            ACT_TRI:   n_item.kind = K_TRI;
            ACT_QUERY: n_item.kind = K_QUERY;
            default:   n_item.kind = K_SKIP;
        endcase
    end

    assign o_s_ready = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_s_valid && o_s_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

[hdl/mpl_back.sv]
// Sequencer: table loads, nearest node scan and triangle containment tests.
module mpl_back
    import mpl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  t_item              i_q_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [TRI_AW-1:0]  o_tri,
    output logic [NODE_AW-1:0] o_near
);
    typedef enum logic [3:0] {
        S_IDLE, S_NRD, S_NMUL, S_NCMP, S_TRD, S_TCHK, S_VRD, S_VLAT,
        S_DIFF, S_MUL, S_SUM, S_EVAL, S_RES
    } t_state;

    t_state                    r_state;
    logic [NC_W-1:0]           r_nc_cfg;
    logic [TC_W-1:0]           r_tc_cfg;
    logic [NC_W-1:0]           nc;
    logic [TC_W-1:0]           tc;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [NC_W-1:0]           r_n;
    logic [TC_W-1:0]           r_t;
    logic                      r_pass;
    logic [NODE_AW-1:0]        r_best;
    logic [PROD_W:0]           r_bestd;
    logic [PROD_W-1:0]         r_sq1, r_sq2;
    logic [NODE_AW-1:0]        r_v [3];
    logic signed [COORD_W-1:0] r_vx [3];
    logic signed [COORD_W-1:0] r_vy [3];
    logic [1:0]                r_k;
    logic [1:0]                r_m;
    logic signed [DIFF_W-1:0]  r_e1, r_e2, r_e3, r_e4, r_f2, r_q1, r_q2;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic signed [ACC_W-1:0]   r_acc [3];
    logic                      r_found;
    logic [TRI_AW-1:0]         r_tri;

    logic                      node_we, tri_we;
    logic [NODE_AW-1:0]        node_raddr;
    logic signed [COORD_W-1:0] node_x, node_y;
    logic [3*NODE_AW-1:0]      tri_rdata;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [PROD_W:0]           sq_sum;
    logic signed [DIFF_W-1:0]  ma1, mb1, ma2, mb2;
    logic signed [ACC_W-1:0]   gval;
    logic                      d_pos, d_neg, a_ok, b_ok, g_ok, a_okn, b_okn, g_okn, inside_hit;
    logic [NODE_AW-1:0]        va, vb, vc;
    logic                      uses_best, vert_bad;

    assign nc = (r_nc_cfg > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : r_nc_cfg;
    assign tc = (r_tc_cfg > TC_W'(MAX_TRIS)) ? TC_W'(MAX_TRIS) : r_tc_cfg;

    assign o_q_ready = (r_state == S_IDLE);
    assign node_we   = o_q_ready && i_q_valid && (i_q_item.kind == K_NODE);
    assign tri_we    = o_q_ready && i_q_valid && (i_q_item.kind == K_TRI);

    always_comb begin
        case (r_state)
            S_VRD:   node_raddr = r_v[r_k];
            default: node_raddr = r_n[NODE_AW-1:0];
        endcase
    end

    mpl_ram #(.WIDTH(COORD_W), .DEPTH(MAX_NODES)) u_node_x (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(i_q_item.slot[NODE_AW-1:0]),
        .i_wdata(i_q_item.pos_x), .i_raddr(node_raddr), .o_rdata(node_x)
    );
    mpl_ram #(.WIDTH(COORD_W), .DEPTH(MAX_NODES)) u_node_y (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(i_q_item.slot[NODE_AW-1:0]),
        .i_wdata(i_q_item.pos_y), .i_raddr(node_raddr), .o_rdata(node_y)
    );
    mpl_ram #(.WIDTH(3*NODE_AW), .DEPTH(MAX_TRIS)) u_tri (
        .i_clk(i_clk), .i_we(tri_we), .i_waddr(i_q_item.slot[TRI_AW-1:0]),
        .i_wdata({i_q_item.vertex_c, i_q_item.vertex_b, i_q_item.vertex_a}),
        .i_raddr(r_t[TRI_AW-1:0]), .o_rdata(tri_rdata)
    );

    assign dx     = DIFF_W'(r_px) - DIFF_W'(node_x);
    assign dy     = DIFF_W'(r_py) - DIFF_W'(node_y);
    assign sq_sum = {1'b0, r_sq1} + {1'b0, r_sq2};

    assign va = tri_rdata[NODE_AW-1:0];
    assign vb = tri_rdata[2*NODE_AW-1:NODE_AW];
    assign vc = tri_rdata[3*NODE_AW-1:2*NODE_AW];
    assign uses_best = (va == r_best) || (vb == r_best) || (vc == r_best);
    assign vert_bad  = ({1'b0, va} >= nc) || ({1'b0, vb} >= nc) || ({1'b0, vc} >= nc);

    // Products per step: step 0 forms the doubled area, steps 1 and 2 the
    // first two barycentric numerators.
    always_comb begin
        case (r_m)
            2'd0: begin
                ma1 = r_e1; mb1 = r_e4; ma2 = r_e2; mb2 = r_f2;
            end
            2'd1: begin
                ma1 = r_e1; mb1 = r_q1; ma2 = r_e2; mb2 = r_q2;
            end
            default: begin
                ma1 = r_e3; mb1 = r_q1; ma2 = r_e4; mb2 = r_q2;
            end
        endcase
    end

    assign gval  = r_acc[0] - r_acc[1] - r_acc[2];
    assign d_pos = !r_acc[0][ACC_W-1] && (r_acc[0] != '0);
    assign d_neg = r_acc[0][ACC_W-1];
    assign a_ok  = !r_acc[1][ACC_W-1];
    assign b_ok  = !r_acc[2][ACC_W-1];
    assign g_ok  = !gval[ACC_W-1];
    assign a_okn = r_acc[1][ACC_W-1] || (r_acc[1] == '0);
    assign b_okn = r_acc[2][ACC_W-1] || (r_acc[2] == '0);
    assign g_okn = gval[ACC_W-1] || (gval == '0);
    assign inside_hit = (d_pos && a_ok && b_ok && g_ok) || (d_neg && a_okn && b_okn && g_okn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nc_cfg    <= '0;
            r_tc_cfg    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NODE_COUNT: r_nc_cfg <= i_cfg_wdata[NC_W-1:0];
                    CFG_TRI_COUNT:  r_tc_cfg <= i_cfg_wdata;
                    default:        r_tc_cfg <= r_tc_cfg;
                endcase
            end
            if (r_state == S_RES && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_item.kind == K_QUERY) begin
                        r_px    <= i_q_item.pos_x;
                        r_py    <= i_q_item.pos_y;
                        r_n     <= '0;
                        r_best  <= '0;
                        r_found <= 1'b0;
                        r_tri   <= '0;
                        r_state <= (nc == '0) ? S_RES : S_NRD;
                    end
                end
                S_NRD: r_state <= S_NMUL;
                S_NMUL: begin
                    r_sq1   <= PROD_W'(dx * dx);
                    r_sq2   <= PROD_W'(dy * dy);
                    r_state <= S_NCMP;
                end
                S_NCMP: begin
                    // The first minimum wins, so only a strictly smaller one replaces it.
                    if (r_n == '0 || sq_sum < r_bestd) begin
                        r_bestd <= sq_sum;
                        r_best  <= r_n[NODE_AW-1:0];
                    end
                    if (r_n + 1'b1 == nc) begin
                        r_t     <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_TRD;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_NRD;
                    end
                end
                S_TRD: begin
                    if (r_t == tc) begin
                        r_t <= '0;
                        if (r_pass) begin
                            r_state <= S_RES;
                        end else begin
                            r_pass <= 1'b1;
                        end
                    end else begin
                        r_state <= S_TCHK;
                    end
                end
                S_TCHK: begin
                    r_v[0] <= va;
                    r_v[1] <= vb;
                    r_v[2] <= vc;
                    r_k    <= '0;
                    if (vert_bad || (!r_pass && !uses_best)) begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_TRD;
                    end else begin
                        r_state <= S_VRD;
                    end
                end
                S_VRD: r_state <= S_VLAT;
                S_VLAT: begin
                    r_vx[r_k] <= node_x;
                    r_vy[r_k] <= node_y;
                    if (r_k == 2'd2) begin
                        r_state <= S_DIFF;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_VRD;
                    end
                end
                S_DIFF: begin
                    r_e1    <= DIFF_W'(r_vy[1]) - DIFF_W'(r_vy[2]);
                    r_e2    <= DIFF_W'(r_vx[2]) - DIFF_W'(r_vx[1]);
                    r_e3    <= DIFF_W'(r_vy[2]) - DIFF_W'(r_vy[0]);
                    r_e4    <= DIFF_W'(r_vx[0]) - DIFF_W'(r_vx[2]);
                    r_f2    <= DIFF_W'(r_vy[0]) - DIFF_W'(r_vy[2]);
                    r_q1    <= DIFF_W'(r_px) - DIFF_W'(r_vx[2]);
                    r_q2    <= DIFF_W'(r_py) - DIFF_W'(r_vy[2]);
                    r_m     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p1    <= ma1 * mb1;
                    r_p2    <= ma2 * mb2;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc[r_m] <= ACC_W'(r_p1) + ACC_W'(r_p2);
                    if (r_m == 2'd2) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_EVAL: begin
                    if (inside_hit) begin
                        r_found <= 1'b1;
                        r_tri   <= r_t[TRI_AW-1:0];
                        r_state <= S_RES;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_RES: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_found     <= r_found;
                        o_tri       <= r_tri;
                        o_near      <= r_best;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/mesh_point_location.sv]
// Top level of the mesh point location block.
// A load passes through the input queue and is written into its table when the idle
// sequencer takes it; loads can follow one per cycle while no query runs. A query starts
// from the idle state, scans the nodes in use for the nearest node, then tests triangles
// over up to two passes of the triangle table, the first only over those that use the
// nearest node, and loads the result register at the end; the node memory has a single
// read port. Tables start undefined, with no clearing pass. Up to two items queue at the
// input while a query runs.
module mesh_point_location
    import mpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // action
    input  logic [1:0]            s_axis_tuser,
    // slot, pos_x, pos_y, vertex_a, vertex_b, vertex_c, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found
    output logic                  m_axis_tuser,
    // triangle_index, nearest_node, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
    logic               q_valid;
    logic               q_ready;
    t_item              q_item;
    logic [TRI_AW-1:0]  tri_idx;
    logic [NODE_AW-1:0] near;

    mpl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .o_s_ready(s_axis_tready),
        .i_s_user(s_axis_tuser), .i_s_data(s_axis_tdata),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_item(q_item)
    );

    mpl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_item(q_item),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_found(m_axis_tuser), .o_tri(tri_idx), .o_near(near)
    );

    assign m_axis_tdata = {(OUT_DATA_W - TRI_AW - NODE_AW)'(0), near, tri_idx};
endmodule

[hdl/mpl_checker.sv]
// Port-level checks of the mesh point location block, bound to the top level.
module mpl_checker
    import mpl_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic                  m_axis_tuser,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[TRI_AW-1:0] == '0)
        else $error("triangle index not zero on a miss");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:TRI_AW+NODE_AW] == '0)
        else $error("fill bits not zero");
endmodule

bind mesh_point_location mpl_checker u_mpl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
);

[verif/testbench.sv]
// Testbench for the mesh point location block: table loads, queries and count settings.
`timescale 1ns / 100ps

module testbench;
    import mpl_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         act;
        logic [12:0]        slot;
        logic [23:0]        px;
        logic [23:0]        py;
        logic [11:0]        va;
        logic [11:0]        vb;
        logic [11:0]        vc;
    } t_load;

    typedef struct packed {
        logic        found;
        logic [12:0] tri_idx;
        logic [11:0] near;
    } t_answer;

    typedef struct {
        t_load   item;
        logic    has_ans;
        t_answer ans;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_addr = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [1:0]            s_axis_tuser = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  m_axis_tuser;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    mesh_point_location u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the tables and counts.
    logic signed [23:0] mesh_x [MAX_NODES];
    logic signed [23:0] mesh_y [MAX_NODES];
    logic [11:0]        tri_v [MAX_TRIS][3];
    int                 nodes_used;
    int                 tris_used;

    t_answer pending_answers[$];
    int      mismatches = 0;
    int      queries_checked = 0;
    int      answers_found = 0;
    longint  cycles = 0;
    bit      hold_off = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd8000000) begin
            $display("timeout with %0d answers outstanding", pending_answers.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic int sgn(logic signed [63:0] v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic bit covers(logic signed [63:0] tx, logic signed [63:0] ty, int t);
        logic signed [63:0] x0, y0, x1, y1, x2, y2, d, a, b, g;
        int sd;
        if (tri_v[t][0] >= nodes_used || tri_v[t][1] >= nodes_used ||
            tri_v[t][2] >= nodes_used) return 1'b0;
        x0 = mesh_x[tri_v[t][0]]; y0 = mesh_y[tri_v[t][0]];
        x1 = mesh_x[tri_v[t][1]]; y1 = mesh_y[tri_v[t][1]];
        x2 = mesh_x[tri_v[t][2]]; y2 = mesh_y[tri_v[t][2]];
        // Products of 25-bit differences fit easily in 64 bits.
        d = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
        a = (y1 - y2) * (tx - x2) + (x2 - x1) * (ty - y2);
        b = (y2 - y0) * (tx - x2) + (x0 - x2) * (ty - y2);
        g = d - a - b;
        sd = sgn(d);
        if (sd == 0) return 1'b0;
        return sgn(a) * sd >= 0 && sgn(b) * sd >= 0 && sgn(g) * sd >= 0;
    endfunction

    function automatic t_answer locate_point(logic signed [23:0] qx, logic signed [23:0] qy);
        t_answer r;
        logic signed [63:0] tx, ty, dx, dy, sq_d, best_sq;
        int best;
        r = '0;
        if (nodes_used == 0) return r;
        tx = qx; ty = qy;
        best = 0; best_sq = 0;
        for (int n = 0; n < nodes_used; n++) begin
            dx = tx - mesh_x[n];
            dy = ty - mesh_y[n];
            sq_d = dx * dx + dy * dy;
            if (n == 0 || sq_d < best_sq) begin
                best_sq = sq_d;
                best = n;
            end
        end
        r.near = best[11:0];
        for (int t = 0; t < tris_used; t++)
            if ((tri_v[t][0] == best || tri_v[t][1] == best || tri_v[t][2] == best) &&
                covers(tx, ty, t)) begin
                r.found = 1'b1; r.tri_idx = t[12:0];
                return r;
            end
        for (int t = 0; t < tris_used; t++)
            if (covers(tx, ty, t)) begin
                r.found = 1'b1; r.tri_idx = t[12:0];
                return r;
            end
        return r;
    endfunction

    function automatic void apply_item(t_load it, output bit has_ans, output t_answer ans);
        has_ans = 1'b0;
        ans = '0;
        case (it.act)
            ACT_NODE: if (it.slot < MAX_NODES) begin
                mesh_x[it.slot] = it.px;
                mesh_y[it.slot] = it.py;
            end
            ACT_TRI: if (it.slot < MAX_TRIS) begin
                tri_v[it.slot][0] = it.va;
                tri_v[it.slot][1] = it.vb;
                tri_v[it.slot][2] = it.vc;
            end
            ACT_QUERY: begin
                has_ans = 1'b1;
                ans = locate_point(it.px, it.py);
            end
            default: ;
        endcase
    endfunction

    // Idle cycles before the next transfer: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        return (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // The valid line stays high after a transfer; the next call either drives
    // the next item in the same time step or drops valid for the gap.
    task automatic send_item(t_load it, bit has_typed, t_answer typed);
        bit has_ans;
        t_answer ans;
        t_answer want_ans;
        int gap;
        apply_item(it, has_ans, ans);
        if (has_ans) begin
            if (has_typed && typed != ans)
                $display("note: typed answer %h differs from predictor %h", typed, ans);
            want_ans = has_typed ? typed : ans;
            pending_answers = {pending_answers, want_ans};
        end
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.act;
        s_axis_tdata  <= {8'd0, it.vc, it.vb, it.va, it.py, it.px, it.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_count(logic idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_NODE_COUNT) nodes_used = (value > MAX_NODES) ? MAX_NODES : value;
        else tris_used = (value > MAX_TRIS) ? MAX_TRIS : value;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        // A load or ignored item may still be in flight after the last answer.
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_load mk(logic [1:0] a, int s, int x, int y, int p, int q, int r);
        t_load it;
        it.act = a; it.slot = s[12:0]; it.px = x[23:0]; it.py = y[23:0];
        it.va = p[11:0]; it.vb = q[11:0]; it.vc = r[11:0];
        return it;
    endfunction

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 9) < 7) || (cycles % 2000 < 300);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_answer got, want;
            got = {m_axis_tuser, m_axis_tdata[12:0], m_axis_tdata[24:13]};
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected answer %h", got);
            end else begin
                want = pending_answers.pop_front();
                queries_checked++;
                if (got.found) answers_found++;
                if (got != want || m_axis_tdata[31:25] != 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("query answer mismatch: found %b/%b tri %0d/%0d node %0d/%0d",
                                 want.found, got.found, want.tri_idx, got.tri_idx,
                                 want.near, got.near);
                end
            end
        end
    end

    t_row   rows[$];
    t_row   row;
    t_load  it;
    int     sz, k, cx, cy, span;

    initial begin
        nodes_used = 0; tris_used = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Query before any node is in use: no node, nothing found.
        row.item = mk(ACT_QUERY, 0, 0, 0, 0, 0, 0); row.has_ans = 1; row.ans = '0;
        rows = {rows, row};
        row.has_ans = 0; row.ans = '0;
        row.item = mk(ACT_NODE, 0, 0, 0, 0, 0, 0);                  rows = {rows, row};
        row.item = mk(ACT_NODE, 1, 8388607, 0, 0, 0, 0);            rows = {rows, row};
        row.item = mk(ACT_NODE, 2, 0, 8388607, 0, 0, 0);            rows = {rows, row};
        row.item = mk(ACT_NODE, 3, -8388608, -8388608, 0, 0, 0);    rows = {rows, row};
        row.item = mk(ACT_NODE, 4, 100, 100, 0, 0, 0);              rows = {rows, row};
        row.item = mk(ACT_NODE, 4095, -5, 7, 0, 0, 0);              rows = {rows, row};
        row.item = mk(ACT_NODE, 8191, 1, 1, 0, 0, 0);               rows = {rows, row};
        row.item = mk(ACT_TRI, 0, 0, 0, 0, 1, 2);                   rows = {rows, row};
        row.item = mk(ACT_TRI, 1, 0, 0, 0, 4, 4);                   rows = {rows, row};
        row.item = mk(ACT_TRI, 2, 0, 0, 3, 1, 2);                   rows = {rows, row};
        row.item = mk(ACT_TRI, 3, 0, 0, 4095, 0, 1);                rows = {rows, row};
        row.item = mk(ACT_TRI, 8191, 0, 0, 0, 1, 2);                rows = {rows, row};
        row.item = mk(ACT_TRI, 4096, 0, 0, 2, 1, 0);                rows = {rows, row};
        row.item = mk(ACT_UNUSED, 8191, -1, -1, 4095, 4095, 4095);  rows = {rows, row};
        for (int i = 0; i < rows.size(); i++)
            send_item(rows[i].item, rows[i].has_ans, rows[i].ans);
        drain();
        rows.delete();

        write_count(CFG_NODE_COUNT, 5);
        write_count(CFG_TRI_COUNT, 4);
        row.item = mk(ACT_QUERY, 0, 10, 10, 0, 0, 0);               rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, 0, 0, 0, 0, 0);                 rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, 8388607, 8388607, 0, 0, 0);     rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, -8388608, 8388607, 0, 0, 0);    rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, 4194303, 4194304, 0, 0, 0);     rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, -3, -3, 0, 0, 0);               rows = {rows, row};
        row.item = mk(ACT_QUERY, 0, 50, 50, 0, 0, 0);               rows = {rows, row};
        for (int i = 0; i < rows.size(); i++) send_item(rows[i].item, 0, '0);
        drain();

        // Random phases: build a small mesh, mostly near a random center, then query it.
        for (int phase = 0; phase < 5; phase++) begin
            sz = $urandom_range(3, 6);
            span = (phase == 2) ? 8388607 : (1 << $urandom_range(4, 20));
            cx = $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 2 * 8000000)) - 8000000;
            cy = $urandom_range(0, 1) ? 0 : $signed($urandom_range(0, 2 * 8000000)) - 8000000;
            for (int n = 0; n < sz; n++) begin
                k = (phase == 2) ? $urandom : cx + $signed($urandom_range(0, 2 * span)) - span;
                it = mk(ACT_NODE, n, k,
                        (phase == 2) ? $urandom : cy + $signed($urandom_range(0, 2 * span)) - span,
                        0, 0, 0);
                send_item(it, 0, '0);
            end
            for (int t = 0; t < sz; t++) begin
                it = mk(ACT_TRI, t, $urandom, $urandom,
                        $urandom_range(0, sz - 1), $urandom_range(0, sz - 1),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, sz - 1));
                send_item(it, 0, '0);
            end
            // Out-of-range loads and unused actions are noise.
            send_item(mk(ACT_NODE, $urandom_range(4096, 8191), $urandom, $urandom, 0, 0, 0),
                      0, '0);
            send_item(mk(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom), 0, '0);
            drain();
            write_count(CFG_NODE_COUNT, (phase == 4) ? 0 : $urandom_range(1, sz));
            write_count(CFG_TRI_COUNT, $urandom_range(0, sz));
            if (phase == 3) hold_off = 1'b1;
            for (int q = 0; q < 6; q++) begin
                if (phase == 2 || $urandom_range(0, 3) == 0) begin
                    it = mk(ACT_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    k = $urandom_range(0, sz - 1);
                    it = mk(ACT_QUERY, $urandom, mesh_x[k] + $signed($urandom_range(0, 64)) - 32,
                            mesh_y[k] + $signed($urandom_range(0, 64)) - 32,
                            $urandom, $urandom, $urandom);
                end
                send_item(it, 0, '0);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("checked %0d query answers, %0d of them inside a triangle",
                 queries_checked, answers_found);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d answers missing", mismatches, pending_answers.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mpl_pkg.sv
hdl/mpl_ram.sv
hdl/mpl_front.sv
hdl/mpl_back.sv
hdl/mesh_point_location.sv
hdl/mpl_checker.sv
verif/testbench.sv
